// ===== hw/rtl/bpad_pkg.sv =====
`timescale 1ns / 1ps

package bpad_pkg;

    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;
    localparam int SIZE_BITS     = 13;
    localparam int COORD_BITS    = 12;
    localparam int PAD_BITS      = 3;
    localparam int RESULT_LIMIT  = 64;
    localparam int COUNT_BITS    = $clog2(RESULT_LIMIT);
    localparam int QUEUE_DEPTH   = 4;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_MAX_PAD    = 7;
    localparam int DEF_PIXEL_BITS = 8;

    localparam logic [SIZE_BITS-1:0] RST_WIDTH  = 13'd640;
    localparam logic [SIZE_BITS-1:0] RST_HEIGHT = 13'd480;
    localparam logic [PAD_BITS-1:0]  RST_PAD_W  = 3'd1;
    localparam logic [PAD_BITS-1:0]  RST_PAD_H  = 3'd1;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_PAD_WIDTH    = 2'd2,
        REG_PAD_HEIGHT   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [SIZE_BITS-1:0] image_width;
        logic [SIZE_BITS-1:0] image_height;
        logic [PAD_BITS-1:0]  pad_width;
        logic [PAD_BITS-1:0]  pad_height;
    } t_cfg;

    // inclusive output spans that clamp onto one source pixel
    typedef struct packed {
        logic [SIZE_BITS-1:0] row_lo;
        logic [SIZE_BITS-1:0] row_hi;
        logic [SIZE_BITS-1:0] col_lo;
        logic [SIZE_BITS-1:0] col_hi;
    } t_span;

endpackage

// ===== hw/rtl/border_replicate_padding_core.sv =====
`timescale 1ns / 1ps

// clamp-to-edge border padding, pixel driven
// input queue side: push a source pixel (row, column, value) while full is low
// result queue side: while empty is low the oldest result is on the o_out_* ports,
// pop takes it; o_last marks the final result caused by one source pixel
// an interior pixel gives one result, an edge pixel a run, a corner pixel a block,
// at most 64 results in row-major order; border-band pixels give none
// a source pixel reaches the result ports via queue, sequencer and output register
// throughput is one result per cycle from the output sequencer while pop is high
// a four-entry request queue lets push continue while a burst is sent
// when pop is held low the output register holds, the sequencer stops and the
// queue fills until full rises; nothing is dropped
// configuration writes go through the APB-style port; the user must make them
// only while the block is idle, which the block itself does not enforce
// reset empties both queues and loads 640 x 480 with a one-pixel border

module border_replicate_padding_core #(
    parameter int MAX_WIDTH  = bpad_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bpad_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_PAD    = bpad_pkg::DEF_MAX_PAD,
    parameter int PIXEL_BITS = bpad_pkg::DEF_PIXEL_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bpad_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [bpad_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [bpad_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    input  logic                                push,
    output logic                                full,
    input  logic [bpad_pkg::COORD_BITS-1:0]     i_pix_row,
    input  logic [bpad_pkg::COORD_BITS-1:0]     i_pix_col,
    input  logic [PIXEL_BITS-1:0]               i_pix_value,
    output logic                                empty,
    input  logic                                pop,
    output logic [bpad_pkg::COORD_BITS-1:0]     o_out_row,
    output logic [bpad_pkg::COORD_BITS-1:0]     o_out_col,
    output logic [PIXEL_BITS-1:0]               o_out_value,
    output logic                                o_last
);
    import bpad_pkg::*;

    localparam int ENTRY_BITS = $bits(t_span) + PIXEL_BITS;

    t_cfg                  cfg;
    t_span                 wr_span;
    t_span                 rd_span;
    logic                  queue_wr;
    logic                  queue_rd;
    logic                  queue_empty;
    logic                  queue_full;
    logic [PIXEL_BITS-1:0] rd_value;

    assign full = queue_full;

    bpad_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bpad_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_PAD    (MAX_PAD)
    ) u_front (
        .i_cfg        (cfg),
        .i_push       (push),
        .i_pix_row    (i_pix_row),
        .i_pix_col    (i_pix_col),
        .i_queue_full (queue_full),
        .o_queue_wr   (queue_wr),
        .o_span       (wr_span)
    );

    bpad_fifo #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (queue_wr),
        .i_wdata ({wr_span, i_pix_value}),
        .i_rd    (queue_rd),
        .o_rdata ({rd_span, rd_value}),
        .o_empty (queue_empty),
        .o_full  (queue_full)
    );

    bpad_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_queue_empty (queue_empty),
        .i_span        (rd_span),
        .i_value       (rd_value),
        .o_queue_rd    (queue_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_out_value   (o_out_value),
        .o_last        (o_last)
    );

endmodule

// ===== hw/rtl/bpad_regs.sv =====
`timescale 1ns / 1ps

module bpad_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bpad_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [bpad_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [bpad_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output bpad_pkg::t_cfg                      o_cfg
);
    import bpad_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (idx)
                REG_IMAGE_WIDTH:  n_cfg.image_width  = pwdata[SIZE_BITS-1:0];
                REG_IMAGE_HEIGHT: n_cfg.image_height = pwdata[SIZE_BITS-1:0];
                REG_PAD_WIDTH:    n_cfg.pad_width    = pwdata[PAD_BITS-1:0];
                REG_PAD_HEIGHT:   n_cfg.pad_height   = pwdata[PAD_BITS-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_IMAGE_WIDTH:  prdata = CFG_DATA_BITS'(r_cfg.image_width);
            REG_IMAGE_HEIGHT: prdata = CFG_DATA_BITS'(r_cfg.image_height);
            REG_PAD_WIDTH:    prdata = CFG_DATA_BITS'(r_cfg.pad_width);
            REG_PAD_HEIGHT:   prdata = CFG_DATA_BITS'(r_cfg.pad_height);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= RST_WIDTH;
            r_cfg.image_height <= RST_HEIGHT;
            r_cfg.pad_width    <= RST_PAD_W;
            r_cfg.pad_height   <= RST_PAD_H;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== hw/rtl/bpad_front.sv =====
`timescale 1ns / 1ps

module bpad_front #(
    parameter int MAX_WIDTH  = bpad_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bpad_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_PAD    = bpad_pkg::DEF_MAX_PAD
) (
    input  bpad_pkg::t_cfg                    i_cfg,
    input  logic                              i_push,
    input  logic [bpad_pkg::COORD_BITS-1:0]   i_pix_row,
    input  logic [bpad_pkg::COORD_BITS-1:0]   i_pix_col,
    input  logic                              i_queue_full,
    output logic                              o_queue_wr,
    output bpad_pkg::t_span                   o_span
);
    import bpad_pkg::*;

    typedef struct packed {
        logic                 ok;
        logic [SIZE_BITS-1:0] lo;
        logic [SIZE_BITS-1:0] hi;
    } t_axis;

    function automatic t_axis axis_span(input logic [COORD_BITS-1:0] p,
                                        input logic [SIZE_BITS-1:0]  size,
                                        input logic [PAD_BITS-1:0]   pad);
        t_axis                a;
        logic [SIZE_BITS-1:0] p_ext;
        logic [SIZE_BITS-1:0] pad_ext;
        logic [SIZE_BITS-1:0] final_pos;
        p_ext     = SIZE_BITS'(p);
        pad_ext   = SIZE_BITS'(pad);
        final_pos = size - pad_ext - SIZE_BITS'(1);
        a.ok = (size > (pad_ext << 1)) && (p_ext >= pad_ext) && (p_ext <= final_pos);
        a.lo = (p_ext == pad_ext) ? '0 : p_ext;
        a.hi = (p_ext == final_pos) ? size - SIZE_BITS'(1) : p_ext;
        return a;
    endfunction

    logic [SIZE_BITS-1:0] w_sat;
    logic [SIZE_BITS-1:0] h_sat;
    logic [PAD_BITS-1:0]  pw_sat;
    logic [PAD_BITS-1:0]  ph_sat;
    t_axis                row_ax;
    t_axis                col_ax;

    assign w_sat  = (32'(i_cfg.image_width) > MAX_WIDTH) ? SIZE_BITS'(MAX_WIDTH)
                                                         : i_cfg.image_width;
    assign h_sat  = (32'(i_cfg.image_height) > MAX_HEIGHT) ? SIZE_BITS'(MAX_HEIGHT)
                                                           : i_cfg.image_height;
    assign pw_sat = (32'(i_cfg.pad_width) > MAX_PAD) ? PAD_BITS'(MAX_PAD) : i_cfg.pad_width;
    assign ph_sat = (32'(i_cfg.pad_height) > MAX_PAD) ? PAD_BITS'(MAX_PAD) : i_cfg.pad_height;

    assign row_ax = axis_span(i_pix_row, h_sat, ph_sat);
    assign col_ax = axis_span(i_pix_col, w_sat, pw_sat);

    // border-band and out-of-range pixels are taken and dropped here
    assign o_queue_wr    = i_push & ~i_queue_full & row_ax.ok & col_ax.ok;
    assign o_span.row_lo = row_ax.lo;
    assign o_span.row_hi = row_ax.hi;
    assign o_span.col_lo = col_ax.lo;
    assign o_span.col_hi = col_ax.hi;

endmodule

// ===== hw/rtl/bpad_fifo.sv =====
`timescale 1ns / 1ps

module bpad_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bpad_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty,
    output logic             o_full
);
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0]     r_mem [DEPTH];
    logic [ADDR_BITS-1:0] r_wr_ptr;
    logic [ADDR_BITS-1:0] r_rd_ptr;
    logic [ADDR_BITS:0]   r_count;
    logic                 do_wr;
    logic                 do_rd;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (ADDR_BITS+1)'(DEPTH));
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_wr   = i_wr & ~o_full;
    assign do_rd   = i_rd & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == ADDR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == ADDR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/bpad_back.sv =====
`timescale 1ns / 1ps

module bpad_back #(
    parameter int PIXEL_BITS = bpad_pkg::DEF_PIXEL_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_queue_empty,
    input  bpad_pkg::t_span                   i_span,
    input  logic [PIXEL_BITS-1:0]             i_value,
    output logic                              o_queue_rd,
    input  logic                              i_pop,
    output logic                              o_empty,
    output logic [bpad_pkg::COORD_BITS-1:0]   o_out_row,
    output logic [bpad_pkg::COORD_BITS-1:0]   o_out_col,
    output logic [PIXEL_BITS-1:0]             o_out_value,
    output logic                              o_last
);
    import bpad_pkg::*;

    t_span                 r_span;
    logic [PIXEL_BITS-1:0] r_value;
    logic                  r_busy;
    logic [SIZE_BITS-1:0]  r_y;
    logic [SIZE_BITS-1:0]  r_x;
    logic [COUNT_BITS-1:0] r_n;

    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_out_row;
    logic [COORD_BITS-1:0] r_out_col;
    logic [PIXEL_BITS-1:0] r_out_value;
    logic                  r_out_last;

    logic out_ready;
    logic emit;
    logic is_last;
    logic load;

    assign out_ready = ~r_out_valid | i_pop;
    assign emit      = r_busy & out_ready;
    // stop at the end of the block or at the result limit, whichever first
    assign is_last   = ((r_x == r_span.col_hi) && (r_y == r_span.row_hi))
                     || (r_n == COUNT_BITS'(RESULT_LIMIT - 1));
    assign load      = (~r_busy | (emit & is_last)) & ~i_queue_empty;
    assign o_queue_rd = load;

    assign o_empty     = ~r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_value;
    assign o_last      = r_out_last;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_row   <= r_y[COORD_BITS-1:0];
            r_out_col   <= r_x[COORD_BITS-1:0];
            r_out_value <= r_value;
            r_out_last  <= is_last;
        end
        if (load) begin
            r_span  <= i_span;
            r_value <= i_value;
            r_y     <= i_span.row_lo;
            r_x     <= i_span.col_lo;
            r_n     <= '0;
        end else if (emit) begin
            r_n <= r_n + 1'b1;
            if (r_x == r_span.col_hi) begin
                r_x <= r_span.col_lo;
                r_y <= r_y + 1'b1;
            end else begin
                r_x <= r_x + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (emit && is_last) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== sim/border_replicate_padding_checker.sv =====
`timescale 1ns / 1ps

module border_replicate_padding_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic                               i_pready,
    input  logic [bpad_pkg::CFG_ADDR_BITS-1:0] i_paddr,
    input  logic [bpad_pkg::CFG_DATA_BITS-1:0] i_pwdata,
    input  logic                               i_push,
    input  logic                               i_full,
    input  logic [bpad_pkg::COORD_BITS-1:0]    i_pix_row,
    input  logic [bpad_pkg::COORD_BITS-1:0]    i_pix_col,
    input  logic [7:0]                         i_pix_value,
    input  logic                               i_pop,
    input  logic                               i_empty,
    input  logic [bpad_pkg::COORD_BITS-1:0]    i_out_row,
    input  logic [bpad_pkg::COORD_BITS-1:0]    i_out_col,
    input  logic [7:0]                         i_out_value,
    input  logic                               i_last,
    output int                                 o_fail_count,
    output int                                 o_waiting
);
    import bpad_pkg::*;

    typedef struct packed {
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
        logic [7:0]            value;
        logic                  last;
    } t_pad_write;

    localparam int PRINT_CAP = 40;

    t_pad_write           clamp_writes_q[$];
    logic [SIZE_BITS-1:0] img_w;
    logic [SIZE_BITS-1:0] img_h;
    logic [PAD_BITS-1:0]  pad_w;
    logic [PAD_BITS-1:0]  pad_h;

    initial begin
        o_fail_count = 0;
        o_waiting    = 0;
    end

    task automatic report_error(input string msg);
        o_fail_count++;
        if (o_fail_count <= PRINT_CAP)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // output span along one axis that clamps onto position p
    function automatic bit clamp_span(input int unsigned p, input int unsigned size,
                                      input int unsigned pad, output int unsigned lo,
                                      output int unsigned hi);
        lo = 0;
        hi = 0;
        if (size <= 2 * pad)
            return 1'b0;
        if (p < pad || p > size - pad - 1)
            return 1'b0;
        lo = (p == pad) ? 0 : p;
        hi = (p == size - pad - 1) ? size - 1 : p;
        return 1'b1;
    endfunction

    task automatic add_clamp_writes(input logic [COORD_BITS-1:0] row,
                                    input logic [COORD_BITS-1:0] col,
                                    input logic [7:0] value);
        int unsigned w, h, pw, ph;
        int unsigned r0, r1, c0, c1, total, n;
        t_pad_write  wr;
        w  = (img_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : img_w;
        h  = (img_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : img_h;
        pw = (pad_w > DEF_MAX_PAD) ? DEF_MAX_PAD : pad_w;
        ph = (pad_h > DEF_MAX_PAD) ? DEF_MAX_PAD : pad_h;
        if (!clamp_span(row, h, ph, r0, r1))
            return;
        if (!clamp_span(col, w, pw, c0, c1))
            return;
        total = (r1 - r0 + 1) * (c1 - c0 + 1);
        if (total > RESULT_LIMIT)
            total = RESULT_LIMIT;
        n = 0;
        for (int unsigned y = r0; y <= r1 && n < total; y++) begin
            for (int unsigned x = c0; x <= c1 && n < total; x++) begin
                wr.row   = COORD_BITS'(y);
                wr.col   = COORD_BITS'(x);
                wr.value = value;
                wr.last  = (n + 1 == total);
                clamp_writes_q.push_back(wr);
                n++;
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_pad_write seen;
        t_pad_write want;
        if (!i_rst_n) begin
            img_w = RST_WIDTH;
            img_h = RST_HEIGHT;
            pad_w = RST_PAD_W;
            pad_h = RST_PAD_H;
            clamp_writes_q.delete();
        end else begin
            // results first, so a request accepted at this edge cannot match them
            if (i_pop && !i_empty) begin
                seen = {i_out_row, i_out_col, i_out_value, i_last};
                if (clamp_writes_q.size() == 0) begin
                    report_error($sformatf("unexpected result row %0d col %0d value %02h last %0b",
                                           i_out_row, i_out_col, i_out_value, i_last));
                end else begin
                    want = clamp_writes_q.pop_front();
                    if (seen !== want)
                        report_error($sformatf(
                            "got row %0d col %0d value %02h last %0b, want %0d %0d %02h %0b",
                            seen.row, seen.col, seen.value, seen.last,
                            want.row, want.col, want.value, want.last));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_IMAGE_WIDTH:  img_w = i_pwdata[SIZE_BITS-1:0];
                    REG_IMAGE_HEIGHT: img_h = i_pwdata[SIZE_BITS-1:0];
                    REG_PAD_WIDTH:    pad_w = i_pwdata[PAD_BITS-1:0];
                    REG_PAD_HEIGHT:   pad_h = i_pwdata[PAD_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_push && !i_full)
                add_clamp_writes(i_pix_row, i_pix_col, i_pix_value);
        end
        o_waiting = clamp_writes_q.size();
    end

endmodule

// ===== sim/border_replicate_padding_core_tb.sv =====
`timescale 1ns / 1ps

module border_replicate_padding_core_tb;
    import bpad_pkg::*;

    localparam int TAIL_CYCLES = 24;

    logic                     i_clk   = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr   = '0;
    logic [CFG_DATA_BITS-1:0] pwdata  = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     push        = 1'b0;
    logic                     full;
    logic [COORD_BITS-1:0]    i_pix_row   = '0;
    logic [COORD_BITS-1:0]    i_pix_col   = '0;
    logic [7:0]               i_pix_value = '0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic [COORD_BITS-1:0]    o_out_row;
    logic [COORD_BITS-1:0]    o_out_col;
    logic [7:0]               o_out_value;
    logic                     o_last;

    int fail_count;
    int waiting;

    // stimulus-side copy of the settings, used only to aim coordinates
    int unsigned cfg_w  = 640;
    int unsigned cfg_h  = 480;
    int unsigned cfg_pw = 1;
    int unsigned cfg_ph = 1;

    bit tx_gaps_en  = 1'b1;
    bit rx_stall_en = 1'b1;
    int burst_left  = 0;
    int pop_run     = 0;

    always #6 i_clk = ~i_clk;

    border_replicate_padding_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .push        (push),
        .full        (full),
        .i_pix_row   (i_pix_row),
        .i_pix_col   (i_pix_col),
        .i_pix_value (i_pix_value),
        .empty       (empty),
        .pop         (pop),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_out_value (o_out_value),
        .o_last      (o_last)
    );

    border_replicate_padding_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_push       (push),
        .i_full       (full),
        .i_pix_row    (i_pix_row),
        .i_pix_col    (i_pix_col),
        .i_pix_value  (i_pix_value),
        .i_pop        (pop),
        .i_empty      (empty),
        .i_out_row    (o_out_row),
        .i_out_col    (o_out_col),
        .i_out_value  (o_out_value),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_waiting    (waiting)
    );

    // receiver: runs of pops broken by stalls of random length
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop     <= 1'b0;
            pop_run <= 0;
        end else if (pop_run == 0) begin
            if (pop && rx_stall_en) begin
                pop     <= 1'b0;
                pop_run <= $urandom_range(1, 14);
            end else begin
                pop     <= 1'b1;
                pop_run <= $urandom_range(1, 24);
            end
        end else begin
            pop_run <= pop_run - 1;
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_frame(input logic [31:0] w, input logic [31:0] h,
                             input logic [31:0] pw, input logic [31:0] ph);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_PAD_WIDTH, pw);
        write_reg(REG_PAD_HEIGHT, ph);
        cfg_w  = w[SIZE_BITS-1:0];
        cfg_h  = h[SIZE_BITS-1:0];
        cfg_pw = pw[PAD_BITS-1:0];
        cfg_ph = ph[PAD_BITS-1:0];
    endtask

    task automatic send_pixel(input logic [COORD_BITS-1:0] row,
                              input logic [COORD_BITS-1:0] col,
                              input logic [7:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            if (tx_gaps_en) begin
                gap = $urandom_range(1, 8);
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        push        <= 1'b1;
        i_pix_row   <= row;
        i_pix_col   <= col;
        i_pix_value <= value;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        burst_left--;
    endtask

    // stop sending and let every outstanding write come out
    task automatic drain_writes();
        push <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (waiting != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    function automatic int unsigned edge_coord(input int unsigned pad, input int unsigned size);
        case ($urandom_range(0, 2))
            0:       return pad;
            1:       return size - pad - 1;
            default: return $urandom_range(pad, size - pad - 1);
        endcase
    endfunction

    // mostly interior and edge pixels; the rest lands in the border band or anywhere
    task automatic send_random_pixel(output bit counted);
        int unsigned w, h, r, c, kind;
        w = (cfg_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : cfg_w;
        h = (cfg_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : cfg_h;
        kind = $urandom_range(0, 99);
        counted = 1'b1;
        if (kind < 45) begin
            r = $urandom_range(cfg_ph, h - cfg_ph - 1);
            c = $urandom_range(cfg_pw, w - cfg_pw - 1);
        end else if (kind < 78) begin
            r = edge_coord(cfg_ph, h);
            c = edge_coord(cfg_pw, w);
        end else if (kind < 90) begin
            counted = 1'b0;
            r = (cfg_ph > 0) ? $urandom_range(0, cfg_ph - 1) : h + $urandom_range(0, 3);
            c = $urandom_range(0, w - 1);
        end else begin
            counted = 1'b0;
            r = $urandom_range(0, 4095);
            c = $urandom_range(0, 4095);
        end
        send_pixel(COORD_BITS'(r), COORD_BITS'(c), 8'($urandom_range(0, 255)));
    endtask

    initial begin
        int unsigned w, h, pw, ph;
        int          done;
        bit          counted;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset frame 640 x 480, one-pixel border
        send_pixel(12'd1, 12'd1, 8'h00);
        send_pixel(12'd1, 12'd638, 8'hFF);
        send_pixel(12'd478, 12'd1, 8'h5A);
        send_pixel(12'd478, 12'd638, 8'hA5);
        send_pixel(12'd1, 12'd300, 8'h3C);
        send_pixel(12'd200, 12'd300, 8'hC3);
        send_pixel(12'd0, 12'd0, 8'h11);
        send_pixel(12'd4095, 12'd4095, 8'hFF);
        drain_writes();

        // oversized width saturates, no border at all
        set_frame(32'h0000_1FFF, 32'd4096, 32'd0, 32'd0);
        send_pixel(12'd0, 12'd0, 8'h00);
        send_pixel(12'd4095, 12'd4095, 8'hFF);
        send_pixel(12'hAAA, 12'h555, 8'h55);
        send_pixel(12'h555, 12'hAAA, 8'hAA);
        drain_writes();

        // one-pixel-tall and -wide interior with the widest border: corner burst is cut short
        set_frame(32'hFFFF_E00F, 32'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pixel(12'd7, 12'd7, 8'h81);
        send_pixel(12'd6, 12'd7, 8'h42);
        drain_writes();

        // smallest image
        set_frame(32'd1, 32'd1, 32'd0, 32'd0);
        send_pixel(12'd0, 12'd0, 8'h7E);
        send_pixel(12'd0, 12'd1, 8'h24);
        drain_writes();

        // degenerate frames: zero width, and border as tall as the image
        set_frame(32'd0, 32'h0000_1FFF, 32'd0, 32'd0);
        send_pixel(12'd0, 12'd0, 8'h99);
        drain_writes();
        set_frame(32'd20, 32'd14, 32'd2, 32'd7);
        send_pixel(12'd7, 12'd5, 8'h66);
        drain_writes();

        for (int phase = 0; phase < 8; phase++) begin
            w = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 24) : $urandom_range(25, 8191);
            h = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 24) : $urandom_range(25, 8191);
            pw = ((w > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : w) - 1) / 2;
            ph = ((h > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : h) - 1) / 2;
            pw = $urandom_range(0, pw > DEF_MAX_PAD ? DEF_MAX_PAD : pw);
            ph = $urandom_range(0, ph > DEF_MAX_PAD ? DEF_MAX_PAD : ph);
            set_frame(w, h, pw, ph);
            tx_gaps_en  = (phase == 0) ? 1'b0 : (phase == 1) ? 1'b1 : 1'($urandom_range(0, 1));
            rx_stall_en = (phase == 0) ? 1'b0 : (phase == 1) ? 1'b1 : 1'($urandom_range(0, 1));
            done = 0;
            while (done < 20) begin
                send_random_pixel(counted);
                if (counted)
                    done++;
                // in phase 3, hold off once mid-phase until the result side is empty
                if (phase == 3 && done == 10 && counted)
                    drain_writes();
            end
            drain_writes();
        end

        if (fail_count == 0 && waiting == 0) begin
            $display("[border_replicate_padding_core] OK");
        end else begin
            $display("[border_replicate_padding_core] ERROR");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("[border_replicate_padding_core] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/bpad_pkg.sv
hw/rtl/bpad_regs.sv
hw/rtl/bpad_front.sv
hw/rtl/bpad_fifo.sv
hw/rtl/bpad_back.sv
hw/rtl/border_replicate_padding_core.sv
sim/border_replicate_padding_checker.sv
sim/border_replicate_padding_core_tb.sv
